>>> src/abge_pkg.sv
package abge_pkg;

    localparam int unsigned PIX_PER_WORD = 8;
    localparam int unsigned WORD_BITS    = 16;
    localparam int unsigned ORIGIN_BITS  = 10;
    localparam int unsigned DIM_BITS     = 8;
    localparam int unsigned COLOUR_BITS  = 8;
    localparam int unsigned CFG_IDX_BITS = 3;
    localparam int unsigned CFG_DAT_BITS = 10;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ORIGIN_X     = 3'd0,
        REG_ORIGIN_Y     = 3'd1,
        REG_CHAR_WIDTH   = 3'd2,
        REG_CHAR_HEIGHT  = 3'd3,
        REG_FORE_COLOUR  = 3'd4,
        REG_BACK_COLOUR  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [ORIGIN_BITS-1:0] origin_x;
        logic [ORIGIN_BITS-1:0] origin_y;
        logic [DIM_BITS-1:0]    char_width;
        logic [DIM_BITS-1:0]    char_height;
        logic [COLOUR_BITS-1:0] fore_colour;
        logic [COLOUR_BITS-1:0] back_colour;
    } t_cfg;

    // Per-word pixel flags: which pixels give a write, and which of those
    // take the foreground colour.
    typedef struct packed {
        logic [PIX_PER_WORD-1:0] write_mask;
        logic [PIX_PER_WORD-1:0] fore_sel;
    } t_pix_flags;

endpackage

>>> src/abge_if.sv
interface abge_in_if;
    logic                             valid;
    logic                             ready;
    logic [abge_pkg::WORD_BITS-1:0]   pixel_word;

    modport source (output valid, output pixel_word, input ready);
    modport sink   (input valid, input pixel_word, output ready);
endinterface

interface abge_out_if #(
    parameter int COORD_WIDTH = 10
);
    logic                              valid;
    logic                              ready;
    logic [COORD_WIDTH-1:0]            pixel_x;
    logic [COORD_WIDTH-1:0]            pixel_y;
    logic [abge_pkg::COLOUR_BITS-1:0]  pixel_colour;
    logic                              last;

    modport source (output valid, output pixel_x, output pixel_y, output pixel_colour,
                    output last, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input pixel_colour,
                    input last, output ready);
endinterface

interface abge_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [abge_pkg::CFG_IDX_BITS-1:0]  index;
    logic [abge_pkg::CFG_DAT_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/abge_cfg.sv
module abge_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    abge_cfg_if.sink          i_cfg,
    output abge_pkg::t_cfg    o_cfg
);

    abge_pkg::t_cfg r_cfg;
    abge_pkg::t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (abge_pkg::t_reg_idx'(i_cfg.index))
                abge_pkg::REG_ORIGIN_X: begin
                    n_cfg.origin_x = i_cfg.data[abge_pkg::ORIGIN_BITS-1:0];
                end
                abge_pkg::REG_ORIGIN_Y: begin
                    n_cfg.origin_y = i_cfg.data[abge_pkg::ORIGIN_BITS-1:0];
                end
                abge_pkg::REG_CHAR_WIDTH: begin
                    n_cfg.char_width = i_cfg.data[abge_pkg::DIM_BITS-1:0];
                end
                abge_pkg::REG_CHAR_HEIGHT: begin
                    n_cfg.char_height = i_cfg.data[abge_pkg::DIM_BITS-1:0];
                end
                abge_pkg::REG_FORE_COLOUR: begin
                    n_cfg.fore_colour = i_cfg.data[abge_pkg::COLOUR_BITS-1:0];
                end
                abge_pkg::REG_BACK_COLOUR: begin
                    n_cfg.back_colour = i_cfg.data[abge_pkg::COLOUR_BITS-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x     <= '0;
            r_cfg.origin_y     <= '0;
            r_cfg.char_width   <= abge_pkg::DIM_BITS'(8);
            r_cfg.char_height  <= abge_pkg::DIM_BITS'(8);
            r_cfg.fore_colour  <= abge_pkg::COLOUR_BITS'(1);
            r_cfg.back_colour  <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

>>> src/abge_walker.sv
module abge_walker #(
    parameter int COORD_WIDTH = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  abge_pkg::t_cfg                      i_cfg,
    input  logic                                i_accept,
    input  logic [abge_pkg::WORD_BITS-1:0]      i_pixel_word,
    output abge_pkg::t_pix_flags                o_flags,
    output logic [COORD_WIDTH-1:0]              o_x0,
    output logic [COORD_WIDTH-1:0]              o_y
);

    localparam int unsigned CB = abge_pkg::DIM_BITS + 1;

    logic [abge_pkg::DIM_BITS-1:0] r_col;
    logic [abge_pkg::DIM_BITS-1:0] r_row;
    logic [abge_pkg::DIM_BITS-1:0] n_col;
    logic [abge_pkg::DIM_BITS-1:0] n_row;
    logic [abge_pkg::DIM_BITS-1:0] row_inc;
    logic [CB-1:0]                 next_col;

    always_comb begin
        for (int i = 0; i < abge_pkg::PIX_PER_WORD; i++) begin
            // A pixel past the glyph width is dropped; alpha clear gives no write.
            o_flags.write_mask[i] = i_pixel_word[2*i+1] &&
                ((CB'(r_col) + CB'(i)) < CB'(i_cfg.char_width));
            o_flags.fore_sel[i]   = i_pixel_word[2*i];
        end
    end

    assign o_x0 = COORD_WIDTH'(i_cfg.origin_x) + COORD_WIDTH'(r_col);
    assign o_y  = COORD_WIDTH'(i_cfg.origin_y) + COORD_WIDTH'(r_row);

    always_comb begin
        next_col = CB'(r_col) + CB'(abge_pkg::PIX_PER_WORD);
        row_inc  = r_row + abge_pkg::DIM_BITS'(1);
        n_col    = r_col;
        n_row    = r_row;
        if (i_accept) begin
            if (next_col >= CB'(i_cfg.char_width)) begin
                n_col = '0;
                n_row = (row_inc >= i_cfg.char_height) ? '0 : row_inc;
            end else begin
                n_col = next_col[abge_pkg::DIM_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

>>> src/abge_emit.sv
module abge_emit #(
    parameter int COORD_WIDTH = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  abge_pkg::t_cfg          i_cfg,
    input  logic                    i_accept,
    input  abge_pkg::t_pix_flags    i_flags,
    input  logic [COORD_WIDTH-1:0]  i_x0,
    input  logic [COORD_WIDTH-1:0]  i_y,
    output logic                    o_take,
    abge_out_if.source              o_pix
);

    localparam int unsigned PB = $clog2(abge_pkg::PIX_PER_WORD);

    // Word register: pixels still to be written for the word in hand.
    logic [abge_pkg::PIX_PER_WORD-1:0] r_mask;
    logic [abge_pkg::PIX_PER_WORD-1:0] r_sel;
    logic [COORD_WIDTH-1:0]            r_x0;
    logic [COORD_WIDTH-1:0]            r_wy;

    // Result register.
    logic                              r_valid;
    logic [COORD_WIDTH-1:0]            r_x;
    logic [COORD_WIDTH-1:0]            r_y;
    logic [abge_pkg::COLOUR_BITS-1:0]  r_colour;
    logic                              r_last;

    logic                              load_out;
    logic [PB-1:0]                     pick;
    logic [abge_pkg::PIX_PER_WORD-1:0] rest;
    logic [abge_pkg::PIX_PER_WORD-1:0] mask_after;

    always_comb begin
        pick = '0;
        for (int i = abge_pkg::PIX_PER_WORD - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                pick = PB'(i);
            end
        end
    end

    assign load_out   = (r_mask != '0) && (!r_valid || o_pix.ready);
    assign rest       = r_mask & ~(abge_pkg::PIX_PER_WORD'(1) << pick);
    assign mask_after = load_out ? rest : r_mask;
    // A new word enters once the last pending write of this one moves out.
    assign o_take     = (mask_after == '0);

    assign o_pix.valid        = r_valid;
    assign o_pix.pixel_x      = r_x;
    assign o_pix.pixel_y      = r_y;
    assign o_pix.pixel_colour = r_colour;
    assign o_pix.last         = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_mask <= i_accept ? i_flags.write_mask : mask_after;
            if (load_out) begin
                r_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_sel <= i_flags.fore_sel;
            r_x0  <= i_x0;
            r_wy  <= i_y;
        end
        if (load_out) begin
            r_x      <= r_x0 + COORD_WIDTH'(pick);
            r_y      <= r_wy;
            r_colour <= r_sel[pick] ? i_cfg.fore_colour : i_cfg.back_colour;
            r_last   <= (rest == '0);
        end
    end

endmodule

>>> src/alpha_bitmap_glyph_expander_core.sv
// Channel   Dir  Word contents
// i_cfg     in   index (3 bits), data (10 bits); always ready
// i_pix     in   pixel_word (16 bits, eight 2-bit pixels)
// o_pix     out  pixel_x, pixel_y, pixel_colour, last
//
// A word gives one pixel write per cycle while the output is not stalled; a fully
// transparent word gives no write. The single result register sets this rate.
// A word is taken in the same cycle its predecessor's final write is loaded.
// Reset is synchronous and active low; it restores the config, counters, pending mask and output valid.
// A stalled output holds its word and the pending pixels; input ready drops while any are pending.
module alpha_bitmap_glyph_expander_core #(
    parameter int COORD_WIDTH = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    abge_cfg_if.sink    i_cfg,
    abge_in_if.sink     i_pix,
    abge_out_if.source  o_pix
);

    abge_pkg::t_cfg         cfg;
    abge_pkg::t_pix_flags   flags;
    logic [COORD_WIDTH-1:0] x0;
    logic [COORD_WIDTH-1:0] y;
    logic                   take;
    logic                   accept;

    assign i_pix.ready = take;
    assign accept      = i_pix.valid && take;

    abge_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    abge_walker #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_accept     (accept),
        .i_pixel_word (i_pix.pixel_word),
        .o_flags      (flags),
        .o_x0         (x0),
        .o_y          (y)
    );

    abge_emit #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (accept),
        .i_flags  (flags),
        .i_x0     (x0),
        .i_y      (y),
        .o_take   (take),
        .o_pix    (o_pix)
    );

endmodule
